[src/dfsmg_pkg.sv]
// ---------------------------------------------------------------------------
// dfsmg_pkg: shared types and constants of the depth-first maze generator
// Cell kinds, commands, the sequencer states and the LFSR step.
// ---------------------------------------------------------------------------
package dfsmg_pkg;

	localparam logic [15:0] SEED_DEFAULT = 16'd44257;

	typedef enum logic [1:0] {
		KIND_WALL  = 2'd0,
		KIND_OPEN  = 2'd1,
		KIND_START = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	localparam logic CMD_GENERATE = 1'b0;
	localparam logic CMD_READ     = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PUSH,
		ST_SHUF,
		ST_TOP,
		ST_PROBE,
		ST_DECIDE,
		ST_MARK_END,
		ST_MARK_START,
		ST_READ,
		ST_READ_WAIT,
		ST_OUT
	} state_t;

	// One right shift of the Fibonacci LFSR x^16+x^14+x^13+x^11+1
	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		logic b;
		b = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {b, v[15:1]};
	endfunction

endpackage

[src/dfsmg_grid_ram.sv]
// ---------------------------------------------------------------------------
// dfsmg_grid_ram: cell store of the maze grid
// One write port and one registered read port, two bits per cell.
// ---------------------------------------------------------------------------
module dfsmg_grid_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);
	logic [1:0] mem [DEPTH];

	// write one cell, read one cell with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/dfsmg_stack_ram.sv]
// ---------------------------------------------------------------------------
// dfsmg_stack_ram: frame stack of the walk
// One write port and one registered read port; 23-bit frames.
// ---------------------------------------------------------------------------
module dfsmg_stack_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [22:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [22:0]   rdata
);
	logic [22:0] mem [DEPTH];

	// write one frame, read one frame with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/dfs_maze_generator_unit.sv]
// A read passes through the read and read-wait states before its result is
// presented. A generate clears every cell, then pushes and shuffles a frame per
// carved cell, probes each direction tried, pops each spent frame, and marks the
// end and start cells. Clear, carve and marking share the grid's one write port.
// One request at a time: tready is low until the result has been taken.
// Reset clears control state and loads the LFSR with 44257; the grid reads as
// all wall through a valid-flag, so no clearing pass runs after reset.
// ---------------------------------------------------------------------------
// dfs_maze_generator_unit: recursive-backtracker maze generator
// Carves a perfect maze by randomised depth-first search over a stack in
// memory, and answers single-cell reads.
// ---------------------------------------------------------------------------
module dfs_maze_generator_unit #(
	parameter int ROWS        = 32,
	parameter int COLS        = 32,
	parameter int STACK_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cmd[0], start_corner[2:1], read_row[8:3], read_col[14:9]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // cell_kind[1:0], end_row[7:2], end_col[13:8]
	output logic        m_tuser    // generated
);
	localparam int CELLS = ROWS * COLS;
	localparam int GAW   = $clog2(CELLS);
	localparam int SAW   = $clog2(STACK_DEPTH);
	localparam int SPW   = $clog2(STACK_DEPTH + 1);

	dfsmg_pkg::state_t state_q, state_d;

	logic [15:0]    lfsr_q;
	logic           gvalid_q;
	logic [GAW-1:0] clr_q;
	logic [SPW-1:0] sp_q;
	logic [5:0]     sr_q, sc_q, er_q, ec_q;
	logic [5:0]     cr_q, cc_q;
	logic [7:0]     ord_q;
	logic [1:0]     shi_q;
	logic [22:0]    frame_q;
	logic [1:0]     kind_q;
	logic           gen_q;
	logic           rd_in_q;

	// grid port
	logic           g_we;
	logic [GAW-1:0] g_waddr, g_raddr;
	logic [1:0]     g_wdata, g_rdata;
	// stack port
	logic           s_we;
	logic [SAW-1:0] s_waddr, s_raddr;
	logic [22:0]    s_wdata, s_rdata;

	dfsmg_grid_ram #(.DEPTH(CELLS), .AW(GAW)) u_grid (
		.clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.raddr(g_raddr), .rdata(g_rdata)
	);
	dfsmg_stack_ram #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	function automatic logic [GAW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
		logic [12:0] a;
		a = 13'(r) * 13'(COLS) + 13'(c);
		return a[GAW-1:0];
	endfunction

	// decode of the top frame
	logic [22:0] top_f;
	logic [2:0] k;
	logic [1:0] dir;
	logic [7:0] nr, nc;   // signed 2-step target
	logic [5:0] wr, wc;
	logic       inb;
	logic [15:0] lfsr_n;
	logic [1:0]  j;
	logic [7:0]  ord_sw;

	always_comb begin
		// the frame arrives from the stack in probe and is held for decide
		top_f = (state_q == dfsmg_pkg::ST_PROBE) ? s_rdata : frame_q;
		k   = top_f[22:20];
		dir = top_f[12 + 2*k[1:0] +: 2];
		nr  = {2'b00, top_f[11:6]};
		nc  = {2'b00, top_f[5:0]};
		wr  = top_f[11:6];
		wc  = top_f[5:0];
		unique case (dir)
			2'd0: begin nc = nc + 8'd2; wc = wc + 6'd1; end
			2'd1: begin nr = nr + 8'd2; wr = wr + 6'd1; end
			2'd2: begin nc = nc - 8'd2; wc = wc - 6'd1; end
			default: begin nr = nr - 8'd2; wr = wr - 6'd1; end
		endcase
		inb = !nr[7] && !nc[7] && (nr < 8'(ROWS)) && (nc < 8'(COLS));
		lfsr_n = dfsmg_pkg::lfsr_next(lfsr_q);
		j = lfsr_n[1:0];
		ord_sw = ord_q;
		ord_sw[2*shi_q +: 2] = ord_q[2*j +: 2];
		ord_sw[2*j +: 2]     = ord_q[2*shi_q +: 2];
	end

	logic [1:0] probe_kind;
	assign probe_kind = gvalid_q ? g_rdata : dfsmg_pkg::KIND_WALL;

	// next state and memory ports
	always_comb begin
		state_d = state_q;
		g_we    = 1'b0;
		g_waddr = cell_addr(cr_q, cc_q);
		g_wdata = dfsmg_pkg::KIND_OPEN;
		g_raddr = cell_addr(nr[5:0], nc[5:0]);
		s_we    = 1'b0;
		s_waddr = sp_q[SAW-1:0];
		s_wdata = {3'd0, ord_q, cr_q, cc_q};
		s_raddr = SAW'(sp_q - SPW'(1));
		unique case (state_q)
			dfsmg_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tdata[0] == dfsmg_pkg::CMD_GENERATE)
						? dfsmg_pkg::ST_CLEAR : dfsmg_pkg::ST_READ;
				end
			end
			dfsmg_pkg::ST_CLEAR: begin
				g_we    = 1'b1;
				g_waddr = clr_q;
				g_wdata = dfsmg_pkg::KIND_WALL;
				if (clr_q == GAW'(CELLS - 1)) state_d = dfsmg_pkg::ST_PUSH;
			end
			dfsmg_pkg::ST_PUSH: begin
				g_we    = 1'b1;
				state_d = dfsmg_pkg::ST_SHUF;
			end
			dfsmg_pkg::ST_SHUF: begin
				if (shi_q == 2'd3) begin
					s_we    = 1'b1;
					s_wdata = {3'd0, ord_sw, cr_q, cc_q};
					state_d = dfsmg_pkg::ST_TOP;
				end
			end
			dfsmg_pkg::ST_TOP: begin
				state_d = (sp_q == '0) ? dfsmg_pkg::ST_MARK_END : dfsmg_pkg::ST_PROBE;
			end
			dfsmg_pkg::ST_PROBE: begin
				// frame read back now; pop it when all four are tried, else step its index; issue the grid read
				if (k[2]) begin
					state_d = dfsmg_pkg::ST_TOP;
				end else begin
					s_we    = 1'b1;
					s_waddr = SAW'(sp_q - SPW'(1));
					s_wdata = {k + 3'd1, top_f[19:0]};
					state_d = dfsmg_pkg::ST_DECIDE;
				end
			end
			dfsmg_pkg::ST_DECIDE: begin
				if (inb && probe_kind == dfsmg_pkg::KIND_WALL
						&& sp_q < SPW'(STACK_DEPTH)) begin
					g_we    = 1'b1;
					g_waddr = cell_addr(wr, wc);
					state_d = dfsmg_pkg::ST_PUSH;
				end else begin
					state_d = dfsmg_pkg::ST_TOP;
				end
			end
			dfsmg_pkg::ST_MARK_END: begin
				g_we    = 1'b1;
				g_waddr = cell_addr(er_q, ec_q);
				g_wdata = dfsmg_pkg::KIND_END;
				state_d = dfsmg_pkg::ST_MARK_START;
			end
			dfsmg_pkg::ST_MARK_START: begin
				g_we    = 1'b1;
				g_waddr = cell_addr(sr_q, sc_q);
				g_wdata = dfsmg_pkg::KIND_START;
				state_d = dfsmg_pkg::ST_OUT;
			end
			dfsmg_pkg::ST_READ: begin
				g_raddr = cell_addr(cr_q, cc_q);
				state_d = dfsmg_pkg::ST_READ_WAIT;
			end
			dfsmg_pkg::ST_READ_WAIT: begin
				state_d = dfsmg_pkg::ST_OUT;
			end
			dfsmg_pkg::ST_OUT: begin
				if (m_tready) state_d = dfsmg_pkg::ST_IDLE;
			end
			default: state_d = dfsmg_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfsmg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q   <= dfsmg_pkg::SEED_DEFAULT;
			gvalid_q <= 1'b0;
			clr_q    <= '0;
			sp_q     <= '0;
			er_q     <= '0;
			ec_q     <= '0;
			sr_q     <= '0;
			sc_q     <= '0;
			cr_q     <= '0;
			cc_q     <= '0;
			ord_q    <= '0;
			shi_q    <= '0;
			kind_q   <= '0;
			gen_q    <= 1'b0;
			rd_in_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				lfsr_q <= (cfg_wdata != 16'd0) ? cfg_wdata : dfsmg_pkg::SEED_DEFAULT;
			end
			unique case (state_q)
				dfsmg_pkg::ST_IDLE: begin
					clr_q <= '0;
					if (s_tvalid && s_tdata[0] == dfsmg_pkg::CMD_GENERATE) begin
						sr_q <= s_tdata[2] ? 6'(ROWS - 1) : 6'd0;
						sc_q <= s_tdata[1] ? 6'(COLS - 1) : 6'd0;
						cr_q <= s_tdata[2] ? 6'(ROWS - 1) : 6'd0;
						cc_q <= s_tdata[1] ? 6'(COLS - 1) : 6'd0;
						er_q <= s_tdata[2] ? 6'(ROWS - 1) : 6'd0;
						ec_q <= s_tdata[1] ? 6'(COLS - 1) : 6'd0;
						sp_q <= '0;
					end else if (s_tvalid) begin
						cr_q    <= s_tdata[8:3];
						cc_q    <= s_tdata[14:9];
						rd_in_q <= ({1'b0, s_tdata[8:3]} < 7'(ROWS))
							&& ({1'b0, s_tdata[14:9]} < 7'(COLS));
					end
				end
				dfsmg_pkg::ST_CLEAR: begin
					clr_q <= clr_q + GAW'(1);
					if (clr_q == GAW'(CELLS - 1)) gvalid_q <= 1'b1;
				end
				dfsmg_pkg::ST_PUSH: begin
					ord_q <= 8'b11_10_01_00;
					shi_q <= 2'd0;
				end
				dfsmg_pkg::ST_SHUF: begin
					// one draw and one swap per cycle
					lfsr_q <= lfsr_n;
					ord_q  <= ord_sw;
					shi_q  <= shi_q + 2'd1;
					if (shi_q == 2'd3) sp_q <= sp_q + SPW'(1);
				end
				dfsmg_pkg::ST_PROBE: begin
					if (k[2]) sp_q <= sp_q - SPW'(1);
				end
				dfsmg_pkg::ST_DECIDE: begin
					if (inb && probe_kind == dfsmg_pkg::KIND_WALL
							&& sp_q < SPW'(STACK_DEPTH)) begin
						cr_q <= nr[5:0];
						cc_q <= nc[5:0];
						er_q <= nr[5:0];
						ec_q <= nc[5:0];
					end
				end
				dfsmg_pkg::ST_MARK_START: begin
					kind_q <= dfsmg_pkg::KIND_WALL;
					gen_q  <= 1'b1;
				end
				dfsmg_pkg::ST_READ_WAIT: begin
					kind_q <= (rd_in_q && gvalid_q) ? g_rdata : dfsmg_pkg::KIND_WALL;
					gen_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// hold the top frame for the decide cycle
	always_ff @(posedge clk) begin
		frame_q <= s_rdata;
	end

	assign s_tready = (state_q == dfsmg_pkg::ST_IDLE);
	assign m_tvalid = (state_q == dfsmg_pkg::ST_OUT);
	assign m_tdata  = {2'b00, ec_q, er_q, kind_q};
	assign m_tuser  = gen_q;

	// a generate never leaves frames behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfsmg_pkg::ST_MARK_END) |-> (sp_q == '0))
		else $error("stack not empty at end of walk");
	// the stack never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond depth");
	// a generate result always reports wall as its kind
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[1:0] == dfsmg_pkg::KIND_WALL))
		else $error("generate result carries a cell kind");
endmodule

[dv/tb_dfs_maze_generator_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dfs_maze_generator_unit: self-checking bench for the maze generator
// Drives generate and cell-read requests over the input stream, predicts
// every maze with its own depth-first carver and compares each response
// field by field, under random gaps, back-pressure and seed changes.
// ---------------------------------------------------------------------------
module tb_dfs_maze_generator_unit;

	localparam int N_ROWS  = 32;
	localparam int N_COLS  = 32;
	localparam int N_DEPTH = 512;
	localparam int SETTLE  = 16;

	typedef struct {
		dfsmg_pkg::kind_t kind;
		logic [5:0]       end_row;
		logic [5:0]       end_col;
		logic             generated;
	} response_t;

	// Maze predictor and store of pending responses
	class maze_scoreboard;
		dfsmg_pkg::kind_t cells[N_ROWS][N_COLS];
		logic [22:0] frames[N_DEPTH];
		int          depth;
		logic [15:0] lfsr;
		logic [5:0]  end_row, end_col;
		response_t   pending[$];
		int          errors, n_generate, n_read, n_outside;

		function new();
			foreach (cells[r, c]) cells[r][c] = dfsmg_pkg::KIND_WALL;
			lfsr = dfsmg_pkg::SEED_DEFAULT;
			end_row = 0;
			end_col = 0;
		endfunction

		function void load_seed(logic [15:0] seed);
			lfsr = (seed != 16'd0) ? seed : dfsmg_pkg::SEED_DEFAULT;
		endfunction

		function logic [1:0] draw();
			lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
			return lfsr[1:0];
		endfunction

		function logic [7:0] shuffle();
			logic [1:0] order[4];
			logic [1:0] j, t;
			for (int i = 0; i < 4; i++) order[i] = i[1:0];
			for (int i = 0; i < 4; i++) begin
				j = draw();
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			return {order[3], order[2], order[1], order[0]};
		endfunction

		function void open_cell(int r, int c);
			cells[r][c] = dfsmg_pkg::KIND_OPEN;
			frames[depth] = {3'd0, shuffle(), r[5:0], c[5:0]};
			depth++;
		endfunction

		// Carve a fresh maze from the given corner
		function void carve(logic [1:0] corner);
			int sr, sc, r, c, nr, nc, dr, dc, lr, lc;
			logic [22:0] f;
			logic [2:0] k;
			logic [1:0] dir;
			sr = corner[1] ? N_ROWS - 1 : 0;
			sc = corner[0] ? N_COLS - 1 : 0;
			lr = sr;
			lc = sc;
			foreach (cells[i, j]) cells[i][j] = dfsmg_pkg::KIND_WALL;
			depth = 0;
			open_cell(sr, sc);
			while (depth > 0) begin
				f = frames[depth - 1];
				k = f[22:20];
				if (k >= 3'd4) begin
					depth--;
					continue;
				end
				frames[depth - 1][22:20] = k + 3'd1;
				dir = f[12 + 2 * k +: 2];
				r = f[11:6];
				c = f[5:0];
				dr = (dir == 2'd1) ? 1 : (dir == 2'd3) ? -1 : 0;
				dc = (dir == 2'd0) ? 1 : (dir == 2'd2) ? -1 : 0;
				nr = r + 2 * dr;
				nc = c + 2 * dc;
				if (nr >= 0 && nr < N_ROWS && nc >= 0 && nc < N_COLS
						&& cells[nr][nc] == dfsmg_pkg::KIND_WALL && depth < N_DEPTH) begin
					cells[r + dr][c + dc] = dfsmg_pkg::KIND_OPEN;
					open_cell(nr, nc);
					lr = nr;
					lc = nc;
				end
			end
			cells[lr][lc] = dfsmg_pkg::KIND_END;
			cells[sr][sc] = dfsmg_pkg::KIND_START;
			end_row = lr[5:0];
			end_col = lc[5:0];
		endfunction

		// Note an accepted request and queue its response
		function void note_request(logic [15:0] data);
			response_t exp;
			exp.kind = dfsmg_pkg::KIND_WALL;
			exp.generated = 1'b0;
			if (data[0] == dfsmg_pkg::CMD_GENERATE) begin
				carve(data[2:1]);
				exp.generated = 1'b1;
				n_generate++;
			end else begin
				n_read++;
				if (data[8:3] < N_ROWS && data[14:9] < N_COLS)
					exp.kind = cells[data[8:3]][data[14:9]];
				else
					n_outside++;
			end
			exp.end_row = end_row;
			exp.end_col = end_col;
			pending.push_back(exp);
		endfunction

		// Compare a response with the oldest expectation
		function void check_result(logic [15:0] data, logic gen);
			response_t exp;
			if (pending.size() == 0) begin
				$error("unexpected response tdata=%h tuser=%b", data, gen);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (data[1:0] !== exp.kind) begin
				$error("cell_kind: expected %0d, got %0d", exp.kind, data[1:0]);
				errors++;
			end
			if (data[7:2] !== exp.end_row) begin
				$error("end_row: expected %0d, got %0d", exp.end_row, data[7:2]);
				errors++;
			end
			if (data[13:8] !== exp.end_col) begin
				$error("end_col: expected %0d, got %0d", exp.end_col, data[13:8]);
				errors++;
			end
			if (gen !== exp.generated) begin
				$error("generated: expected %0d, got %0d", exp.generated, gen);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;

	maze_scoreboard sb = new();
	bit no_idle = 1'b0;
	int hold_off = 0;

	dfs_maze_generator_unit #(
		.ROWS(N_ROWS), .COLS(N_COLS), .STACK_DEPTH(N_DEPTH)
	) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every accepted response
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);

	// Receiver: random stalls per response, plus one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready = 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send(logic cmd, logic [1:0] corner, logic [5:0] row, logic [5:0] col);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		repeat (gap) @(negedge clk);
		s_tdata = {1'b0, col, row, corner, cmd};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(s_tdata);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_seed(logic [15:0] seed);
		drain();
		cfg_wdata = seed;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.load_seed(seed);
	endtask

	task automatic read_end();
		send(dfsmg_pkg::CMD_READ, 2'd0, sb.end_row, sb.end_col);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			send(dfsmg_pkg::CMD_GENERATE, 2'($urandom_range(0, 3)), 6'($urandom),
				6'($urandom));
		else if (pick < 20)
			read_end();
		else if (pick < 40)
			send(dfsmg_pkg::CMD_READ, 2'($urandom), 6'($urandom), 6'($urandom));
		else
			send(dfsmg_pkg::CMD_READ, 2'($urandom), 6'($urandom_range(0, N_ROWS - 1)),
				6'($urandom_range(0, N_COLS - 1)));
	endtask

	initial begin
		logic [15:0] seeds[5];
		seeds = '{16'd44257, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000};
		seeds[4] = 16'($urandom_range(1, 65535));
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reads of the reset grid, then each corner and its cells
		send(dfsmg_pkg::CMD_READ, 2'd0, 6'd0, 6'd0);
		send(dfsmg_pkg::CMD_READ, 2'd3, 6'd63, 6'd63);
		for (int corner = 0; corner < 4; corner++) begin
			send(dfsmg_pkg::CMD_GENERATE, corner[1:0], 6'd0, 6'd0);
			read_end();
			send(dfsmg_pkg::CMD_READ, 2'd0, corner[1] ? 6'd31 : 6'd0,
				corner[0] ? 6'd31 : 6'd0);
			send(dfsmg_pkg::CMD_READ, 2'd0, 6'd1, 6'd0);
		end
		send(dfsmg_pkg::CMD_READ, 2'd0, 6'd32, 6'd0);
		send(dfsmg_pkg::CMD_READ, 2'd0, 6'd0, 6'd32);
		send(dfsmg_pkg::CMD_READ, 2'd0, 6'd31, 6'd31);
		send(dfsmg_pkg::CMD_READ, 2'd0, 6'd63, 6'd63);

		// Random phases, each after the first with a new seed setting
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) write_seed(seeds[phase]);
			if (phase == 3) send(dfsmg_pkg::CMD_GENERATE, 2'd0, 6'd0, 6'd0);
			for (int n = 0; n < 112; n++) begin
				no_idle = (n >= 40 && n < 60);
				if (phase == 2 && n == 30) hold_off = 400;
				if (n == 80) drain();
				random_item();
			end
			no_idle = 1'b0;
		end

		drain();
		$display("Covered %0d generates and %0d reads (%0d outside the grid)",
			sb.n_generate, sb.n_read, sb.n_outside);
		$display("over five seed settings including zero, one and all ones.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_dfs_maze_generator_unit passed");
		end else begin
			$display("tb_dfs_maze_generator_unit failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("tb_dfs_maze_generator_unit failed");
		$finish;
	end

endmodule

[sim.f]
src/dfsmg_pkg.sv
src/dfsmg_grid_ram.sv
src/dfsmg_stack_ram.sv
src/dfs_maze_generator_unit.sv
dv/tb_dfs_maze_generator_unit.sv
